### rtl/websocket_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// websocket_frame_deframer assertion macros
// Shared concurrent assertion forms; the using module provides clock and reset.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define WSD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wsd assertion failed");

// next-cycle implication
`define WSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wsd assertion failed");

`endif

### rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types, codes and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

   localparam int LENGTH_WIDTH_DEFAULT = 64;
   localparam int BUF_SIZE_WIDTH       = 17;
   localparam logic [BUF_SIZE_WIDTH-1:0] BUF_SIZE_RESET  = 17'd4096;
   localparam logic [BUF_SIZE_WIDTH-1:0] HEADER_OVERHEAD = 17'd6;

   // header fields
   localparam int FIN_BIT  = 7;
   localparam int MASK_BIT = 7;
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES    = 4'd2;
   localparam logic [3:0] EXT64_BYTES    = 4'd8;

   // opcodes
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;

   // result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_FIN_CLEAR = 3'd1;
   localparam logic [2:0] ERR_RSV_SET   = 3'd2;
   localparam logic [2:0] ERR_UNMASKED  = 3'd3;
   localparam logic [2:0] ERR_TOO_LARGE = 3'd4;
   localparam logic [2:0] ERR_BAD_OP    = 3'd5;

   typedef enum logic [4:0] {
      PH_HDR0    = 5'b00001,
      PH_HDR1    = 5'b00010,
      PH_EXTLEN  = 5'b00100,
      PH_MASK    = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] data_byte;
      logic [3:0] frame_opcode;
      logic       last_of_frame;
      logic [2:0] error_code;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } step_result_type;

   function automatic step_result_type make_result(
      input logic [1:0] kind,
      input logic [7:0] data,
      input logic [3:0] op,
      input logic       last,
      input logic [2:0] err
   );
      step_result_type res;
      res.valid              = 1'b1;
      res.item.result_kind   = kind;
      res.item.data_byte     = data;
      res.item.frame_opcode  = op;
      res.item.last_of_frame = last;
      res.item.error_code    = err;
      return res;
   endfunction

endpackage

### rtl/wsd_stream_if.sv
// ----------------------------------------------------------------------------
// wsd_stream_if
// Valid/ready item channel with a typed payload.
// ----------------------------------------------------------------------------
interface wsd_stream_if #(
   parameter type ITEM_TYPE = logic
) ();
   logic     valid;
   logic     ready;
   ITEM_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/wsd_step.sv
// ----------------------------------------------------------------------------
// wsd_step
// Frame parser state and the per-byte step: header checks, length decode,
// mask capture and payload unmasking.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_assert.svh"

module wsd_step #(
   parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  logic [7:0]                         rx_byte,
   input  logic [wsd_pkg::BUF_SIZE_WIDTH-1:0] buffer_size,
   output wsd_pkg::step_result_type           result
);

   localparam int CMP_WIDTH = (LENGTH_WIDTH > wsd_pkg::BUF_SIZE_WIDTH) ?
                              LENGTH_WIDTH : wsd_pkg::BUF_SIZE_WIDTH;

   wsd_pkg::phase_type      phase_ff, phase_in;
   logic [3:0]              count_ff, count_in;
   logic [3:0]              opcode_ff, opcode_in;
   logic [LENGTH_WIDTH-1:0] remaining_ff, remaining_in;
   logic [3:0][7:0]         key_ff, key_in;
   logic [1:0]              mask_index_ff, mask_index_in;
   logic                    halted_ff, halted_in;
   logic                    overflow_ff, overflow_in;

   logic [LENGTH_WIDTH-1:0] ext_length;
   logic [LENGTH_WIDTH-1:0] rem_dec;
   logic                    overflow_now;
   logic [CMP_WIDTH-1:0]    len_candidate;
   logic [CMP_WIDTH-1:0]    limit;
   logic                    too_large;
   logic [7:0]              unmasked;

   assign ext_length   = {remaining_ff[LENGTH_WIDTH-9:0], rx_byte};
   assign overflow_now = overflow_ff || (remaining_ff[LENGTH_WIDTH-1 -: 8] != 8'd0);
   assign rem_dec      = remaining_ff - LENGTH_WIDTH'(1);
   assign unmasked     = rx_byte ^ key_ff[mask_index_ff];

   // one compare serves both the short length and the extended length
   assign len_candidate = (phase_ff == wsd_pkg::PH_HDR1) ? CMP_WIDTH'(rx_byte[6:0])
                                                         : CMP_WIDTH'(ext_length);
   assign limit     = CMP_WIDTH'(buffer_size - wsd_pkg::HEADER_OVERHEAD);
   assign too_large = (buffer_size < wsd_pkg::HEADER_OVERHEAD) || (len_candidate > limit);

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      opcode_in     = opcode_ff;
      remaining_in  = remaining_ff;
      key_in        = key_ff;
      mask_index_in = mask_index_ff;
      halted_in     = halted_ff;
      overflow_in   = overflow_ff;
      result        = '0;

      if (!halted_ff) begin
         case (phase_ff)
            wsd_pkg::PH_HDR0: begin
               if (!rx_byte[wsd_pkg::FIN_BIT]) begin
                  result    = wsd_pkg::make_result(wsd_pkg::KIND_ERROR, 8'd0, rx_byte[3:0],
                                                   1'b0, wsd_pkg::ERR_FIN_CLEAR);
                  halted_in = 1'b1;
               end else begin
                  opcode_in = rx_byte[3:0];
                  if (rx_byte[6:4] != 3'd0) begin
                     result    = wsd_pkg::make_result(wsd_pkg::KIND_ERROR, 8'd0, rx_byte[3:0],
                                                      1'b0, wsd_pkg::ERR_RSV_SET);
                     halted_in = 1'b1;
                  end else begin
                     phase_in = wsd_pkg::PH_HDR1;
                  end
               end
            end
            wsd_pkg::PH_HDR1: begin
               if (!rx_byte[wsd_pkg::MASK_BIT]) begin
                  result    = wsd_pkg::make_result(wsd_pkg::KIND_ERROR, 8'd0, opcode_ff,
                                                   1'b0, wsd_pkg::ERR_UNMASKED);
                  halted_in = 1'b1;
               end else begin
                  remaining_in = '0;
                  overflow_in  = 1'b0;
                  count_in     = 4'd0;
                  if (rx_byte[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
                     count_in = wsd_pkg::EXT16_BYTES;
                     phase_in = wsd_pkg::PH_EXTLEN;
                  end else if (rx_byte[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
                     count_in = wsd_pkg::EXT64_BYTES;
                     phase_in = wsd_pkg::PH_EXTLEN;
                  end else begin
                     remaining_in = LENGTH_WIDTH'(rx_byte[6:0]);
                     if ((rx_byte[6:0] != 7'd0) && too_large) begin
                        result    = wsd_pkg::make_result(wsd_pkg::KIND_ERROR, 8'd0, opcode_ff,
                                                         1'b0, wsd_pkg::ERR_TOO_LARGE);
                        halted_in = 1'b1;
                     end else begin
                        phase_in = wsd_pkg::PH_MASK;
                     end
                  end
               end
            end
            wsd_pkg::PH_EXTLEN: begin
               overflow_in  = overflow_now;
               remaining_in = ext_length;
               count_in     = count_ff - 4'd1;
               if (count_ff == 4'd1) begin
                  if (overflow_now || ((ext_length != '0) && too_large)) begin
                     result    = wsd_pkg::make_result(wsd_pkg::KIND_ERROR, 8'd0, opcode_ff,
                                                      1'b0, wsd_pkg::ERR_TOO_LARGE);
                     halted_in = 1'b1;
                  end else begin
                     phase_in = wsd_pkg::PH_MASK;
                  end
               end
            end
            wsd_pkg::PH_MASK: begin
               key_in[count_ff[1:0]] = rx_byte;
               if (count_ff[1:0] == 2'd3) begin
                  count_in      = 4'd0;
                  mask_index_in = 2'd0;
                  phase_in      = (remaining_ff == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
               end else begin
                  count_in = {2'b00, count_ff[1:0] + 2'd1};
               end
            end
            wsd_pkg::PH_PAYLOAD: begin
               mask_index_in = mask_index_ff + 2'd1;
               remaining_in  = rem_dec;
               if ((opcode_ff == wsd_pkg::OP_TEXT) || (opcode_ff == wsd_pkg::OP_BINARY)) begin
                  result = wsd_pkg::make_result(wsd_pkg::KIND_DATA, unmasked, opcode_ff,
                                                rem_dec == '0, wsd_pkg::ERR_NONE);
                  if (rem_dec == '0) begin
                     phase_in = wsd_pkg::PH_HDR0;
                  end
               end else if (rem_dec == '0) begin
                  halted_in = 1'b1;
                  if (opcode_ff == wsd_pkg::OP_CLOSE) begin
                     result = wsd_pkg::make_result(wsd_pkg::KIND_CLOSE, 8'd0, wsd_pkg::OP_CLOSE,
                                                   1'b1, wsd_pkg::ERR_NONE);
                  end else begin
                     result = wsd_pkg::make_result(wsd_pkg::KIND_ERROR, 8'd0, opcode_ff,
                                                   1'b1, wsd_pkg::ERR_BAD_OP);
                  end
               end
            end
            default: begin
               phase_in = wsd_pkg::PH_HDR0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= wsd_pkg::PH_HDR0;
         count_ff      <= 4'd0;
         opcode_ff     <= 4'd0;
         remaining_ff  <= '0;
         mask_index_ff <= 2'd0;
         halted_ff     <= 1'b0;
         overflow_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         opcode_ff     <= opcode_in;
         remaining_ff  <= remaining_in;
         mask_index_ff <= mask_index_in;
         halted_ff     <= halted_in;
         overflow_ff   <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         key_ff <= key_in;
      end
   end

   `WSD_ASSERT_SAME(a_halted_silent, halted_ff, !result.valid)
   `WSD_ASSERT_SAME(a_data_only_text_binary,
      result.valid && (result.item.result_kind == wsd_pkg::KIND_DATA),
      (result.item.error_code == wsd_pkg::ERR_NONE) &&
      ((opcode_ff == wsd_pkg::OP_TEXT) || (opcode_ff == wsd_pkg::OP_BINARY)))
   `WSD_ASSERT_NEXT(a_last_byte_leaves_payload,
      fire && !halted_ff && (phase_ff == wsd_pkg::PH_PAYLOAD) &&
      (remaining_ff == LENGTH_WIDTH'(1)),
      (phase_ff != wsd_pkg::PH_PAYLOAD) || halted_ff)

endmodule

### rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Client-to-server WebSocket frame parser, one received byte per item.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                             handshake
//  req_chan  in   rx_byte                                             valid/ready
//  rsp_chan  out  result_kind data_byte frame_opcode last_of_frame    valid/ready
//                 error_code
//  csr_*     in   buffer_size (17 bits)                               write enable
//
//  One byte per cycle while the result slot drains; a taken byte is held in the
//  input register, then its parse step writes the result register.
//  Bytes that give no result advance even while a result waits downstream.
//  Synchronous active-high reset; buffer_size returns to 4096.
//  After an error or close result the parser drops all bytes until reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
   parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   wsd_stream_if.sink                         req_chan,
   wsd_stream_if.source                       rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [wsd_pkg::BUF_SIZE_WIDTH-1:0] csr_wr_data
);

   logic [wsd_pkg::BUF_SIZE_WIDTH-1:0] buffer_size_ff;
   logic                               in_valid_ff, in_valid_in;
   logic [7:0]                         in_byte_ff;
   logic                               out_valid_ff, out_valid_in;
   wsd_pkg::rsp_item_type              out_item_ff;
   wsd_pkg::step_result_type           step_res;
   logic                               step_fire;
   logic                               req_take;

   // a step only needs the result slot when it produces a result
   assign step_fire = in_valid_ff &&
                      (!step_res.valid || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || step_fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take ? 1'b1 : (step_fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = (step_fire && step_res.valid) ? 1'b1 :
                         (rsp_chan.ready ? 1'b0 : out_valid_ff);

   wsd_step #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_step (
      .clock       (clock),
      .reset       (reset),
      .fire        (step_fire),
      .rx_byte     (in_byte_ff),
      .buffer_size (buffer_size_ff),
      .result      (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= wsd_pkg::BUF_SIZE_RESET;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            buffer_size_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.payload.rx_byte;
      end
      if (step_fire && step_res.valid) begin
         out_item_ff <= step_res.item;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

endmodule
